[hdl/sapd_pkg.sv]
`timescale 1ns / 1ps
package sapd_pkg;
  localparam int MaxLen = 64;
  localparam int SymbolBits = 8;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [SymbolBits-1:0] sym_t;
endpackage

[hdl/sapd_mem.sv]
`timescale 1ns / 1ps
module sapd_mem #(
  parameter int Width = 6,
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/suffix_array_prefix_doubling.sv]
`timescale 1ns / 1ps
// Suffix array builder by prefix doubling.
// Symbols arrive one beat at a time: a beat is taken when start is high and
// busy is low, so the block takes one symbol per cycle while it is idle. The
// beat whose last_symbol is set closes the string and busy rises while the
// build runs. At most 64 symbols are kept; extra ones are dropped. The build
// is one small sequencer that walks the stores through a single registered
// read port each. The first pass is an insertion sort of positions by symbol;
// each doubling round then re-sorts the positions by rank pairs, and there
// are ceil(log2 n) rounds. The next string waits for the build to finish.
// When done, n result beats come out, each marked by strobe for one cycle;
// last_result marks the final one. The receiver cannot stall. busy falls with
// the last result beat. Synchronous reset clears the sequencer and the symbol
// count; the stores need no clearing.
module suffix_array_prefix_doubling
  import sapd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] symbol,
  input  logic       last_symbol,
  output logic       strobe,
  output logic [5:0] suffix_start,
  output logic [5:0] position_rank,
  output logic       last_result
);
  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0, S_INS_A = 5'd1, S_INS_B = 5'd2,
    S_INS_C = 5'd3, S_INS_D = 5'd4, S_INS_E = 5'd5, S_RK0_A = 5'd6,
    S_RK0_B = 5'd7, S_RK0_C = 5'd8, S_RND = 5'd9, S_SK1 = 5'd10,
    S_SK2_A = 5'd11, S_SK2_B = 5'd12, S_CLR = 5'd13, S_CNT_A = 5'd14,
    S_CNT_B = 5'd15, S_CNT_C = 5'd16, S_PFX_A = 5'd17, S_PFX_B = 5'd18,
    S_PL_A = 5'd19, S_PL_B = 5'd20, S_PL_C = 5'd21, S_PL_D = 5'd22,
    S_PR_A = 5'd23, S_PR_B = 5'd24, S_PR_C = 5'd25, S_RR_A = 5'd26,
    S_RR_B = 5'd27, S_RR_C = 5'd28, S_OUT_A = 5'd29, S_OUT_B = 5'd30;

  logic [4:0] state;
  cnt_t n, i, j, m, acc;
  idx_t p, tmp, prev_rank;
  sym_t key, prev_key;
  logic [12:0] prev_pair;

  // Store ports.
  logic sym_we, ord_we, rnk_we, sko_we, bkt_we, pr_we;
  idx_t sym_wa, ord_wa, rnk_wa, sko_wa, bkt_wa, pr_wa;
  idx_t sym_ra, ord_ra, rnk_ra, sko_ra, bkt_ra, pr_ra;
  sym_t sym_wd, sym_rd;
  idx_t ord_wd, ord_rd, rnk_wd, rnk_rd, sko_wd, sko_rd;
  cnt_t bkt_wd, bkt_rd;
  logic [12:0] pr_wd, pr_rd;

  // Helper terms for the datapath.
  logic [7:0] sum_im;
  logic has_second;
  logic sym_first;
  logic rr_first;
  logic sko_take;
  cnt_t ord_minus_m;
  cnt_t sk_fill;
  cnt_t bkt_dec;
  cnt_t pfx_sum;

  assign busy = (state != S_IDLE);

  assign sum_im = {1'b0, i} + {1'b0, m};
  assign has_second = (sum_im < {1'b0, n});
  assign sym_first = (i == '0) || (sym_rd != prev_key);
  assign rr_first = (i == '0) || (pr_rd != prev_pair);
  assign sko_take = ({1'b0, ord_rd} >= m) && (j < n);
  assign ord_minus_m = {1'b0, ord_rd} - m;
  assign sk_fill = n - m + i;
  assign bkt_dec = bkt_rd - 7'd1;
  assign pfx_sum = acc + bkt_rd;

  // Read-address selection per state; read data comes back registered.
  always_comb begin
    sym_ra = i[IdxW-1:0];
    ord_ra = i[IdxW-1:0];
    rnk_ra = i[IdxW-1:0];
    sko_ra = i[IdxW-1:0];
    bkt_ra = i[IdxW-1:0];
    pr_ra  = i[IdxW-1:0];
    unique case (state)
      S_INS_C: begin
        ord_ra = j[IdxW-1:0] - 6'd1;
      end
      S_INS_D, S_RK0_B: begin
        sym_ra = ord_rd;
      end
      S_CNT_B, S_PL_C: begin
        bkt_ra = rnk_rd;
      end
      S_PL_A: begin
        sko_ra = i[IdxW-1:0] - 6'd1;
      end
      S_PL_B: begin
        rnk_ra = sko_rd;
      end
      S_PR_B: begin
        rnk_ra = sum_im[IdxW-1:0];
      end
      S_RR_B: begin
        pr_ra = ord_rd;
      end
      default: begin
      end
    endcase
  end

  // Write-port selection per state.
  always_comb begin
    sym_we = 1'b0;
    sym_wa = n[IdxW-1:0];
    sym_wd = symbol[SymbolBits-1:0];
    ord_we = 1'b0;
    ord_wa = j[IdxW-1:0];
    ord_wd = i[IdxW-1:0];
    rnk_we = 1'b0;
    rnk_wa = tmp;
    rnk_wd = i[IdxW-1:0];
    sko_we = 1'b0;
    sko_wa = i[IdxW-1:0];
    sko_wd = sk_fill[IdxW-1:0];
    bkt_we = 1'b0;
    bkt_wa = i[IdxW-1:0];
    bkt_wd = '0;
    pr_we  = 1'b0;
    pr_wa  = i[IdxW-1:0];
    pr_wd  = {tmp, has_second, has_second ? rnk_rd : 6'd0};
    unique case (state)
      S_IDLE: begin
        sym_we = start && (n < CntW'(MaxLen));
      end
      S_INS_C: begin
        ord_we = (j == '0);
      end
      S_INS_E: begin
        ord_we = 1'b1;
        if (sym_rd > key) begin
          ord_wd = tmp;
        end
      end
      S_RK0_C: begin
        rnk_we = 1'b1;
        if (!sym_first) begin
          rnk_wd = prev_rank;
        end
      end
      S_SK1: begin
        sko_we = (i != m);
      end
      S_SK2_B: begin
        sko_we = sko_take;
        sko_wa = j[IdxW-1:0];
        sko_wd = ord_minus_m[IdxW-1:0];
      end
      S_CLR: begin
        bkt_we = 1'b1;
      end
      S_CNT_C: begin
        bkt_we = 1'b1;
        bkt_wa = tmp;
        bkt_wd = bkt_rd + 7'd1;
      end
      S_PFX_B: begin
        bkt_we = 1'b1;
        bkt_wd = pfx_sum;
      end
      S_PL_D: begin
        bkt_we = (bkt_rd != '0);
        bkt_wa = tmp;
        bkt_wd = bkt_dec;
        ord_we = (bkt_rd != '0);
        ord_wa = bkt_dec[IdxW-1:0];
        ord_wd = p;
      end
      S_PR_C: begin
        pr_we = 1'b1;
      end
      S_RR_C: begin
        rnk_we = 1'b1;
        if (!rr_first) begin
          rnk_wd = prev_rank;
        end
      end
      default: begin
      end
    endcase
  end

  // Stores, one write port and one registered read port each.
  sapd_mem #(.Width(SymbolBits), .Depth(MaxLen), .AddrW(IdxW)) u_sym (
    .clk(clk), .we(sym_we), .waddr(sym_wa), .wdata(sym_wd), .raddr(sym_ra),
    .rdata(sym_rd)
  );
  sapd_mem #(.Width(IdxW), .Depth(MaxLen), .AddrW(IdxW)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra),
    .rdata(ord_rd)
  );
  sapd_mem #(.Width(IdxW), .Depth(MaxLen), .AddrW(IdxW)) u_rnk (
    .clk(clk), .we(rnk_we), .waddr(rnk_wa), .wdata(rnk_wd), .raddr(rnk_ra),
    .rdata(rnk_rd)
  );
  sapd_mem #(.Width(IdxW), .Depth(MaxLen), .AddrW(IdxW)) u_sko (
    .clk(clk), .we(sko_we), .waddr(sko_wa), .wdata(sko_wd), .raddr(sko_ra),
    .rdata(sko_rd)
  );
  sapd_mem #(.Width(CntW), .Depth(MaxLen), .AddrW(IdxW)) u_bkt (
    .clk(clk), .we(bkt_we), .waddr(bkt_wa), .wdata(bkt_wd), .raddr(bkt_ra),
    .rdata(bkt_rd)
  );
  sapd_mem #(.Width(13), .Depth(MaxLen), .AddrW(IdxW)) u_pr (
    .clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra),
    .rdata(pr_rd)
  );

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      i <= '0;
      j <= '0;
      m <= 7'd1;
      strobe <= 1'b0;
      last_result <= 1'b0;
      suffix_start <= '0;
      position_rank <= '0;
    end else begin
      strobe <= 1'b0;
      last_result <= 1'b0;
      unique case (state)
        // Load one symbol per beat; the last one starts the build.
        S_IDLE: begin
          if (start) begin
            if (n < CntW'(MaxLen)) begin
              n <= n + 7'd1;
            end
            if (last_symbol) begin
              i <= '0;
              state <= S_INS_A;
            end
          end
        end
        // Insertion sort of positions by symbol.
        S_INS_A: begin
          if (i == n) begin
            i <= '0;
            state <= S_RK0_A;
          end else begin
            j <= i;
            state <= S_INS_B;
          end
        end
        S_INS_B: begin
          key <= sym_rd;
          state <= S_INS_C;
        end
        S_INS_C: begin
          if (j == '0) begin
            i <= i + 7'd1;
            state <= S_INS_A;
          end else begin
            state <= S_INS_D;
          end
        end
        S_INS_D: begin
          tmp <= ord_rd;
          state <= S_INS_E;
        end
        S_INS_E: begin
          if (sym_rd > key) begin
            j <= j - 7'd1;
            state <= S_INS_C;
          end else begin
            i <= i + 7'd1;
            state <= S_INS_A;
          end
        end
        // First ranks from symbols in sorted order.
        S_RK0_A: begin
          if (i == n) begin
            m <= 7'd1;
            state <= S_RND;
          end else begin
            state <= S_RK0_B;
          end
        end
        S_RK0_B: begin
          tmp <= ord_rd;
          state <= S_RK0_C;
        end
        S_RK0_C: begin
          if (sym_first) begin
            prev_rank <= i[IdxW-1:0];
          end
          prev_key <= sym_rd;
          i <= i + 7'd1;
          state <= S_RK0_A;
        end
        // Round head.
        S_RND: begin
          i <= '0;
          if (m >= n) begin
            state <= S_OUT_A;
          end else begin
            state <= S_SK1;
          end
        end
        // Order by second key; empty second halves go first.
        S_SK1: begin
          if (i == m) begin
            j <= m;
            i <= '0;
            state <= S_SK2_A;
          end else begin
            i <= i + 7'd1;
          end
        end
        S_SK2_A: begin
          if (i == n) begin
            i <= '0;
            state <= S_CLR;
          end else begin
            state <= S_SK2_B;
          end
        end
        S_SK2_B: begin
          if (sko_take) begin
            j <= j + 7'd1;
          end
          i <= i + 7'd1;
          state <= S_SK2_A;
        end
        // Clear the buckets that ranks below n can reach.
        S_CLR: begin
          if (i == n - 7'd1) begin
            i <= '0;
            state <= S_CNT_A;
          end else begin
            i <= i + 7'd1;
          end
        end
        // Count positions per first-key rank.
        S_CNT_A: begin
          if (i == n) begin
            i <= '0;
            acc <= '0;
            state <= S_PFX_A;
          end else begin
            state <= S_CNT_B;
          end
        end
        S_CNT_B: begin
          tmp <= rnk_rd;
          state <= S_CNT_C;
        end
        S_CNT_C: begin
          i <= i + 7'd1;
          state <= S_CNT_A;
        end
        // Running sum turns counts into bucket ends.
        S_PFX_A: begin
          if (i == n) begin
            state <= S_PL_A;
          end else begin
            state <= S_PFX_B;
          end
        end
        S_PFX_B: begin
          acc <= pfx_sum;
          i <= i + 7'd1;
          state <= S_PFX_A;
        end
        // Place positions from the back of the second-key order.
        S_PL_A: begin
          if (i == '0) begin
            state <= S_PR_A;
          end else begin
            state <= S_PL_B;
          end
        end
        S_PL_B: begin
          p <= sko_rd;
          state <= S_PL_C;
        end
        S_PL_C: begin
          tmp <= rnk_rd;
          state <= S_PL_D;
        end
        S_PL_D: begin
          i <= i - 7'd1;
          state <= S_PL_A;
        end
        // Build the rank pair of every position.
        S_PR_A: begin
          if (i == n) begin
            i <= '0;
            state <= S_RR_A;
          end else begin
            state <= S_PR_B;
          end
        end
        S_PR_B: begin
          tmp <= rnk_rd;
          state <= S_PR_C;
        end
        S_PR_C: begin
          i <= i + 7'd1;
          state <= S_PR_A;
        end
        // Re-rank from pairs in sorted order.
        S_RR_A: begin
          if (i == n) begin
            m <= {m[CntW-2:0], 1'b0};
            state <= S_RND;
          end else begin
            state <= S_RR_B;
          end
        end
        S_RR_B: begin
          tmp <= ord_rd;
          state <= S_RR_C;
        end
        S_RR_C: begin
          if (rr_first) begin
            prev_rank <= i[IdxW-1:0];
          end
          prev_pair <= pr_rd;
          i <= i + 7'd1;
          state <= S_RR_A;
        end
        // Emit one result beat per pass through the output states.
        S_OUT_A: begin
          state <= S_OUT_B;
        end
        S_OUT_B: begin
          strobe <= 1'b1;
          suffix_start <= ord_rd;
          position_rank <= rnk_rd;
          if (i == n - 7'd1) begin
            last_result <= 1'b1;
            n <= '0;
            state <= S_IDLE;
          end else begin
            i <= i + 7'd1;
            state <= S_OUT_A;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Protocol and bookkeeping checks.
  a_last_with_strobe: assert property (@(posedge clk) disable iff (rst)
    last_result |-> strobe);
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CntW'(MaxLen));
  a_busy_has_string: assert property (@(posedge clk) disable iff (rst)
    busy |-> (n != '0));
  a_strobe_spacing: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe);
endmodule
